// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the flash disk window cache.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define FDW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fdw assertion failed");
// Condition that must never be seen outside reset
`define FDW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fdw forbidden condition seen");
`else
`define FDW_ASSERT(lbl, clk, rst_n, prop)
`define FDW_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/fdw_pkg.sv =====
// Package for the flash disk window cache: codes, defaults and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package fdw_pkg;

    // Geometry
    localparam int BLOCK_BYTES         = 512;
    localparam int OFF_W               = 9;
    localparam int DISK_BLOCKS_DEF     = 1024;
    localparam int WINDOW_BLOCKS_DEF   = 8;
    localparam int FLUSH_BASE_W        = 10;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int LBA_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TEST_READY = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_START_STOP = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_OTHER      = 3'd4;

    // SCSI command codes that are accepted
    localparam logic [BYTE_W-1:0] CMD_PREVENT_ALLOW = 8'h1E;
    localparam logic [BYTE_W-1:0] CMD_SYNC_CACHE    = 8'h35;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_READY = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_READY = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_PROTECT   = 3'd3,
        STAT_INVALID   = 3'd4
    } fdw_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FLUSH,
        S_LOAD,
        S_WRITE,
        S_DONE
    } fdw_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic ready;
        logic clr;
        logic rd_issue;
        logic wr_byte;
        logic div_start;
        logic div_step;
        logic flush_step;
        logic load_step;
        logic finish;
    } fdw_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic rd_go;
        logic wr_go;
        logic fl_go;
        logic hit;
        logic need_fl;
        logic copy_last;
        logic out_free;
    } fdw_stat_t;

endpackage

// ===== hw/rtl/fdw_if.sv =====
// Channel interfaces of the flash disk window cache: request, response
// and config write. Depends on fdw_pkg.
`timescale 1ns / 1ps

interface fdw_req_if;
    logic                          valid;
    logic                          ready;
    logic [fdw_pkg::OPCODE_W-1:0]  opcode;
    logic [fdw_pkg::LBA_W-1:0]     lba;
    logic [fdw_pkg::OFF_W-1:0]     byte_offset;
    logic [fdw_pkg::BYTE_W-1:0]    write_data;
    logic                          start_flag;
    logic [fdw_pkg::BYTE_W-1:0]    command_code;
    logic                          transfer_last;

    modport source (output valid, opcode, lba, byte_offset, write_data, start_flag,
                    command_code, transfer_last, input ready);
    modport sink   (input valid, opcode, lba, byte_offset, write_data, start_flag,
                    command_code, transfer_last, output ready);
endinterface

interface fdw_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [fdw_pkg::STATUS_W-1:0]     status;
    logic [fdw_pkg::BYTE_W-1:0]       read_data;
    logic                             flush_done;
    logic [fdw_pkg::FLUSH_BASE_W-1:0] flush_base;
    logic                             transfer_done;

    modport source (output valid, status, read_data, flush_done, flush_base,
                    transfer_done, input ready);
    modport sink   (input valid, status, read_data, flush_done, flush_base,
                    transfer_done, output ready);
endinterface

interface fdw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fdw_pkg::CFG_IDX_W-1:0] index;
    logic                          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fdw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module fdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/fdw_ctrl.sv =====
// Controller state machine of the flash disk window cache.
// Depends on fdw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  fdw_pkg::fdw_stat_t stat,
    output fdw_pkg::fdw_cmd_t  cmd
);

    fdw_pkg::fdw_state_t state_reg;
    fdw_pkg::fdw_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdw_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdw_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = fdw_pkg::S_IDLE;
                end
            end
            fdw_pkg::S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = fdw_pkg::S_EXEC;
                end
            end
            fdw_pkg::S_EXEC:
            begin
                if (stat.wr_go && !stat.hit)
                begin
                    state_next = fdw_pkg::S_DIV;
                end
                else if (stat.fl_go && stat.need_fl)
                begin
                    state_next = fdw_pkg::S_FLUSH;
                end
                else
                begin
                    state_next = fdw_pkg::S_DONE;
                end
            end
            fdw_pkg::S_DIV:
            begin
                state_next = stat.need_fl ? fdw_pkg::S_FLUSH : fdw_pkg::S_LOAD;
            end
            fdw_pkg::S_FLUSH:
            begin
                if (stat.copy_last)
                begin
                    state_next = stat.wr_go ? fdw_pkg::S_LOAD : fdw_pkg::S_DONE;
                end
            end
            fdw_pkg::S_LOAD:
            begin
                if (stat.copy_last)
                begin
                    state_next = fdw_pkg::S_WRITE;
                end
            end
            fdw_pkg::S_WRITE:
            begin
                state_next = fdw_pkg::S_DONE;
            end
            fdw_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = fdw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fdw_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            fdw_pkg::S_CLEAR: cmd.clr = 1'b1;
            fdw_pkg::S_IDLE:  cmd.ready = 1'b1;
            fdw_pkg::S_EXEC:
            begin
                if (stat.rd_go)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else if (stat.wr_go)
                begin
                    cmd.wr_byte   = stat.hit;
                    cmd.div_start = !stat.hit;
                end
            end
            fdw_pkg::S_DIV:   cmd.div_step = 1'b1;
            fdw_pkg::S_FLUSH: cmd.flush_step = 1'b1;
            fdw_pkg::S_LOAD:  cmd.load_step = 1'b1;
            fdw_pkg::S_WRITE: cmd.wr_byte = 1'b1;
            fdw_pkg::S_DONE:  cmd.finish = stat.out_free;
            default:          cmd = '0;
        endcase
    end

    // A load always starts from a clean window
    `FDW_ASSERT(a_load_clean, clk, rst_n, (state_reg == fdw_pkg::S_LOAD) |-> !stat.need_fl)
    // The byte write after a load lands in the new window
    `FDW_ASSERT(a_write_hits, clk, rst_n, (state_reg == fdw_pkg::S_WRITE) |-> stat.hit)
    // A finished load is always followed by the byte write
    `FDW_ASSERT(a_load_then_write, clk, rst_n,
        (state_reg == fdw_pkg::S_LOAD && stat.copy_last) |=> (state_reg == fdw_pkg::S_WRITE))

endmodule

// ===== hw/rtl/fdw_dp.sv =====
// Datapath of the flash disk window cache: request capture, checks,
// window and medium RAMs, copy counter, window base logic, result register.
// Depends on fdw_pkg, fdw_if, fdw_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdw_dp #(
    parameter int DISK_BLOCKS   = fdw_pkg::DISK_BLOCKS_DEF,
    parameter int WINDOW_BLOCKS = fdw_pkg::WINDOW_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    fdw_req_if.sink            req,
    fdw_rsp_if.source          rsp,
    fdw_cfg_if.sink            cfg,
    input  fdw_pkg::fdw_cmd_t  cmd,
    output fdw_pkg::fdw_stat_t stat
);

    localparam int WIN_BYTES = WINDOW_BLOCKS * fdw_pkg::BLOCK_BYTES;
    localparam int MED_BYTES = DISK_BLOCKS * fdw_pkg::BLOCK_BYTES;
    localparam int WA  = $clog2(WIN_BYTES);
    localparam int MA  = $clog2(MED_BYTES);
    localparam int BW  = $clog2(DISK_BLOCKS);
    localparam int CW  = $clog2(WIN_BYTES + 1);
    localparam int PW  = $clog2((DISK_BLOCKS + WINDOW_BLOCKS) * fdw_pkg::BLOCK_BYTES) + 1;
    localparam int LW  = fdw_pkg::LBA_W;
    localparam int WL  = $clog2(WINDOW_BLOCKS);
    localparam int QW  = 2 * BW + 1;
    // Rounded-up reciprocal of WINDOW_BLOCKS, exact for every BW-bit block
    localparam logic [BW:0] RECIP =
        (BW+1)'(((64'd1 << (BW + WL)) + 64'(WINDOW_BLOCKS) - 64'd1) / 64'(WINDOW_BLOCKS));

    // Captured request
    logic [fdw_pkg::OPCODE_W-1:0] op_reg;
    logic [LW-1:0]                lba_reg;
    logic [fdw_pkg::OFF_W-1:0]    off_reg;
    logic [fdw_pkg::BYTE_W-1:0]   wdata_reg;
    logic                         start_reg;
    logic [fdw_pkg::BYTE_W-1:0]   code_reg;
    logic                         last_reg;

    // Config and window state
    logic          wen_reg;
    logic          mrdy_reg;
    logic [BW-1:0] base_reg;
    logic [BW-1:0] nb_reg;
    logic          loaded_reg;
    logic          dirty_reg;
    logic          hit_reg;
    logic          pe_reg;
    logic          fdone_reg;
    logic [fdw_pkg::FLUSH_BASE_W-1:0] fbase_reg;
    logic [CW-1:0] cnt_reg;
    logic [MA-1:0] clr_cnt_reg;
    logic [BW-1:0] dq_reg;

    // Result register
    logic                               out_valid_reg;
    fdw_pkg::fdw_status_t               res_status_reg;
    logic [fdw_pkg::BYTE_W-1:0]         res_rdata_reg;
    logic                               res_fdone_reg;
    logic [fdw_pkg::FLUSH_BASE_W-1:0]   res_fbase_reg;
    logic                               res_tdone_reg;

    fdw_pkg::fdw_status_t status;
    logic          accept;
    logic          in_range;
    logic [LW-1:0] diff;
    logic          hit;
    logic [WA-1:0] win_ex_addr;
    logic [MA-1:0] med_ex_addr;
    logic [BW-1:0] cbase;
    logic [PW-1:0] rd_pos;
    logic [PW-1:0] wr_pos;
    logic          rd_pe;
    logic          wr_pe;
    logic          copy_last;
    logic [QW-1:0] qprod;

    logic                       win_we, win_re, med_we, med_re;
    logic [WA-1:0]              win_waddr, win_raddr;
    logic [MA-1:0]              med_waddr, med_raddr;
    logic [fdw_pkg::BYTE_W-1:0] win_wdata, win_q, med_wdata, med_q;

    assign accept    = req.valid && cmd.ready;
    assign req.ready = cmd.ready;
    assign cfg.ready = 1'b1;

    // Request checks
    assign in_range = lba_reg < LW'(DISK_BLOCKS);
    always_comb
    begin
        case (op_reg)
            fdw_pkg::OP_READ:
            begin
                if (!mrdy_reg)      status = fdw_pkg::STAT_NOT_READY;
                else if (!in_range) status = fdw_pkg::STAT_RANGE;
                else                status = fdw_pkg::STAT_OK;
            end
            fdw_pkg::OP_WRITE:
            begin
                if (!mrdy_reg)      status = fdw_pkg::STAT_NOT_READY;
                else if (!wen_reg)  status = fdw_pkg::STAT_PROTECT;
                else if (!in_range) status = fdw_pkg::STAT_RANGE;
                else                status = fdw_pkg::STAT_OK;
            end
            fdw_pkg::OP_TEST_READY:
                status = mrdy_reg ? fdw_pkg::STAT_OK : fdw_pkg::STAT_NOT_READY;
            fdw_pkg::OP_START_STOP:
                status = fdw_pkg::STAT_OK;
            fdw_pkg::OP_OTHER:
            begin
                if (code_reg == fdw_pkg::CMD_SYNC_CACHE || code_reg == fdw_pkg::CMD_PREVENT_ALLOW)
                    status = fdw_pkg::STAT_OK;
                else
                    status = fdw_pkg::STAT_INVALID;
            end
            default: status = fdw_pkg::STAT_INVALID;
        endcase
    end

    // Window hit and byte addresses
    assign diff        = lba_reg - LW'(base_reg);
    assign hit         = loaded_reg && (lba_reg >= LW'(base_reg)) &&
                         (diff < LW'(WINDOW_BLOCKS));
    assign win_ex_addr = WA'({diff, off_reg});
    assign med_ex_addr = MA'({lba_reg, off_reg});

    // Copy positions on the medium
    assign cbase     = cmd.flush_step ? base_reg : nb_reg;
    assign rd_pos    = PW'({cbase, {fdw_pkg::OFF_W{1'b0}}}) + PW'(cnt_reg);
    assign wr_pos    = rd_pos - PW'(1);
    assign rd_pe     = rd_pos >= PW'(MED_BYTES);
    assign wr_pe     = wr_pos >= PW'(MED_BYTES);
    assign copy_last = cnt_reg == CW'(WIN_BYTES);

    // Status to the controller
    always_comb
    begin
        stat.in_valid  = req.valid;
        stat.clr_last  = clr_cnt_reg == MA'(MED_BYTES - 1);
        stat.rd_go     = (op_reg == fdw_pkg::OP_READ) && (status == fdw_pkg::STAT_OK);
        stat.wr_go     = (op_reg == fdw_pkg::OP_WRITE) && (status == fdw_pkg::STAT_OK);
        stat.fl_go     = ((op_reg == fdw_pkg::OP_START_STOP) && !start_reg) ||
                         ((op_reg == fdw_pkg::OP_OTHER) && (code_reg == fdw_pkg::CMD_SYNC_CACHE));
        stat.hit       = hit;
        stat.need_fl   = loaded_reg && dirty_reg;
        stat.copy_last = copy_last;
        stat.out_free  = !out_valid_reg || rsp.ready;
    end

    // Window RAM port selection
    always_comb
    begin
        win_we    = 1'b0;
        win_waddr = win_ex_addr;
        win_wdata = wdata_reg;
        win_re    = 1'b0;
        win_raddr = win_ex_addr;
        if (cmd.wr_byte)
        begin
            win_we = 1'b1;
        end
        else if (cmd.load_step)
        begin
            win_we    = cnt_reg != '0;
            win_waddr = WA'(cnt_reg - CW'(1));
            win_wdata = pe_reg ? fdw_pkg::ERASED_BYTE : med_q;
        end
        if (cmd.rd_issue)
        begin
            win_re = hit;
        end
        else if (cmd.flush_step)
        begin
            win_re    = !copy_last;
            win_raddr = WA'(cnt_reg);
        end
    end

    // Medium RAM port selection
    always_comb
    begin
        med_we    = 1'b0;
        med_waddr = clr_cnt_reg;
        med_wdata = fdw_pkg::ERASED_BYTE;
        med_re    = 1'b0;
        med_raddr = med_ex_addr;
        if (cmd.clr)
        begin
            med_we = 1'b1;
        end
        else if (cmd.flush_step)
        begin
            med_we    = (cnt_reg != '0) && !wr_pe;
            med_waddr = MA'(wr_pos);
            med_wdata = win_q;
        end
        if (cmd.rd_issue)
        begin
            med_re = !hit;
        end
        else if (cmd.load_step)
        begin
            med_re    = !copy_last && !rd_pe;
            med_raddr = MA'(rd_pos);
        end
    end

    fdw_ram #(.WIDTH(fdw_pkg::BYTE_W), .DEPTH(WIN_BYTES)) u_win_ram (
        .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
        .re(win_re), .raddr(win_raddr), .rdata(win_q)
    );

    fdw_ram #(.WIDTH(fdw_pkg::BYTE_W), .DEPTH(MED_BYTES)) u_med_ram (
        .clk(clk), .we(med_we), .waddr(med_waddr), .wdata(med_wdata),
        .re(med_re), .raddr(med_raddr), .rdata(med_q)
    );

    // Window number of the block by reciprocal multiplication
    assign qprod = QW'(lba_reg[BW-1:0]) * QW'(RECIP);

    // Request capture (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.opcode;
            lba_reg   <= req.lba;
            off_reg   <= req.byte_offset;
            wdata_reg <= req.write_data;
            start_reg <= req.start_flag;
            code_reg  <= req.command_code;
            last_reg  <= req.transfer_last;
        end
        if (cmd.load_step)
        begin
            pe_reg <= rd_pe;
        end
        if (cmd.rd_issue)
        begin
            hit_reg <= hit;
        end
        if (cmd.div_start)
        begin
            dq_reg <= BW'(qprod >> (BW + WL));
        end
        if (cmd.div_step)
        begin
            nb_reg <= dq_reg * BW'(WINDOW_BLOCKS);
        end
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wen_reg     <= 1'b1;
            mrdy_reg    <= 1'b1;
            base_reg    <= '0;
            loaded_reg  <= 1'b0;
            dirty_reg   <= 1'b0;
            fdone_reg   <= 1'b0;
            fbase_reg   <= '0;
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    fdw_pkg::CFG_WRITE_ENABLE: wen_reg  <= cfg.data;
                    fdw_pkg::CFG_MEDIUM_READY: mrdy_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + MA'(1);
            end
            if (accept)
            begin
                fdone_reg <= 1'b0;
                fbase_reg <= '0;
            end
            if (cmd.flush_step || cmd.load_step)
            begin
                cnt_reg <= copy_last ? '0 : cnt_reg + CW'(1);
            end
            if (cmd.flush_step && copy_last)
            begin
                dirty_reg <= 1'b0;
                fdone_reg <= 1'b1;
                fbase_reg <= fdw_pkg::FLUSH_BASE_W'(base_reg);
            end
            if (cmd.load_step && copy_last)
            begin
                base_reg   <= nb_reg;
                loaded_reg <= 1'b1;
                dirty_reg  <= 1'b0;
            end
            if (cmd.wr_byte)
            begin
                dirty_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status_reg <= status;
            res_rdata_reg  <= stat.rd_go ? (hit_reg ? win_q : med_q) : '0;
            res_fdone_reg  <= fdone_reg;
            res_fbase_reg  <= fbase_reg;
            res_tdone_reg  <= (stat.rd_go || stat.wr_go) && last_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = res_status_reg;
    assign rsp.read_data     = res_rdata_reg;
    assign rsp.flush_done    = res_fdone_reg;
    assign rsp.flush_base    = res_fbase_reg;
    assign rsp.transfer_done = res_tdone_reg;

    // A dirty window is always a loaded one
    `FDW_ASSERT(a_dirty_loaded, clk, rst_n, dirty_reg |-> loaded_reg)
    // The copy counter only moves during a flush or a load
    `FDW_ASSERT(a_cnt_copy, clk, rst_n, (cnt_reg != '0) |-> (cmd.flush_step || cmd.load_step))
    // No request is taken while the medium is being erased
    `FDW_ASSERT_NEVER(a_no_req_clear, clk, rst_n, cmd.clr && accept)

endmodule

// ===== hw/rtl/flash_disk_window_cache_unit.sv =====
// Top level of the flash disk window cache. Depends on fdw_pkg, fdw_if,
// fdw_ctrl and fdw_dp.
`timescale 1ns / 1ps

// One request at a time. After reset the medium is erased to 0xFF by a pass
// over the whole medium during which no request is taken (config writes are).
// Reads, window-hit writes and commands pass through capture, execute (one
// RAM read or write) and result. A write outside the window adds a step for
// the window base, a load of the window from the medium and the store of the
// byte, with a write-back of the old window first when it is dirty;
// sync-cache and stop-unit cost that write-back when dirty. The copy between
// the window RAM and the medium RAM moves one byte per cycle. A response
// waiting on the output does not block capture of the next request.
module flash_disk_window_cache_unit #(
    parameter int DISK_BLOCKS   = fdw_pkg::DISK_BLOCKS_DEF,
    parameter int WINDOW_BLOCKS = fdw_pkg::WINDOW_BLOCKS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    fdw_req_if.sink   req,
    fdw_rsp_if.source rsp,
    fdw_cfg_if.sink   cfg
);

    fdw_pkg::fdw_cmd_t  cmd;
    fdw_pkg::fdw_stat_t stat;

    fdw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .stat(stat), .cmd(cmd)
    );

    fdw_dp #(
        .DISK_BLOCKS(DISK_BLOCKS),
        .WINDOW_BLOCKS(WINDOW_BLOCKS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
        .cmd(cmd), .stat(stat)
    );

endmodule

// ===== tb/fdw_tb_if.sv =====
// Testbench copy point for the channel interfaces: none needed here beyond the RTL ones.
// This file holds small shared testbench types. Depends on fdw_pkg.
`timescale 1ns / 1ps

package fdw_tb_pkg;
    import fdw_pkg::*;

    // One expected response
    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [BYTE_W-1:0]       read_data;
        logic                    flush_done;
        logic [FLUSH_BASE_W-1:0] flush_base;
        logic                    transfer_done;
    } fdw_resp_t;

    // One request
    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [LBA_W-1:0]    lba;
        logic [OFF_W-1:0]    byte_offset;
        logic [BYTE_W-1:0]   write_data;
        logic                start_flag;
        logic [BYTE_W-1:0]   command_code;
        logic                transfer_last;
    } fdw_item_t;
endpackage

// ===== tb/testbench.sv =====
// Testbench for flash_disk_window_cache_unit: drives requests and config writes,
// predicts each response with a behavioral cache model. Depends on fdw_pkg, fdw_tb_pkg, fdw_if and the top.
`timescale 1ns / 1ps

module testbench;
    import fdw_pkg::*;
    import fdw_tb_pkg::*;

    localparam int DISK_BLOCKS = DISK_BLOCKS_DEF;
    localparam int WIN_BLOCKS  = WINDOW_BLOCKS_DEF;
    localparam int MEDIUM_BYTES = DISK_BLOCKS * BLOCK_BYTES;
    localparam int WIN_BYTES    = WIN_BLOCKS * BLOCK_BYTES;
    // slowest item: divide, write-back, load, plus stalls
    localparam int SLOW_ITEM   = 2 * (WIN_BYTES + 1) + 64;
    localparam int CLEAR_CYCLES = MEDIUM_BYTES + 100;
    localparam longint CYCLE_LIMIT = 4 * (longint'(CLEAR_CYCLES) + 1300 * longint'(SLOW_ITEM));

    logic clk;
    logic rst_n;

    fdw_req_if req ();
    fdw_rsp_if rsp ();
    fdw_cfg_if cfg ();

    flash_disk_window_cache_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Predictor state
    logic [BYTE_W-1:0] medium_img [MEDIUM_BYTES];
    logic [BYTE_W-1:0] win_img [WIN_BYTES];
    int unsigned       win_base;
    bit                win_loaded;
    bit                win_dirty;
    bit                wr_enable;
    bit                med_ready;

    fdw_resp_t pending_resp[$];
    int        error_count;
    int        items_sent;
    int        resp_seen;
    int        flush_seen;
    longint    cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Write back a dirty window into the medium image
    function automatic bit flush_win_img();
        int unsigned start;
        if (!win_loaded || !win_dirty)
            return 0;
        start = win_base * BLOCK_BYTES;
        for (int i = 0; i < WIN_BYTES; i++)
            if (start + i < MEDIUM_BYTES)
                medium_img[start + i] = win_img[i];
        win_dirty = 0;
        return 1;
    endfunction

    // Make the window of lba resident; returns 1 when a write-back happened
    function automatic bit load_win_img(int unsigned lba, output int unsigned old_base);
        int unsigned base;
        int unsigned start;
        bit          flushed;
        base = lba - (lba % WIN_BLOCKS);
        old_base = win_base;
        if (win_loaded && win_base == base)
            return 0;
        flushed = flush_win_img();
        start = base * BLOCK_BYTES;
        for (int i = 0; i < WIN_BYTES; i++)
            win_img[i] = (start + i < MEDIUM_BYTES) ? medium_img[start + i] : ERASED_BYTE;
        win_base = base;
        win_loaded = 1;
        win_dirty = 0;
        return flushed;
    endfunction

    // Expected response for one request, updating the cache image
    function automatic fdw_resp_t predict_cache_resp(fdw_item_t it);
        fdw_resp_t   r;
        int unsigned ob;
        r = '{STAT_OK, '0, 1'b0, '0, 1'b0};
        case (it.opcode)
            OP_READ:
                if (!med_ready)
                    r.status = STAT_NOT_READY;
                else if (it.lba >= DISK_BLOCKS)
                    r.status = STAT_RANGE;
                else
                begin
                    if (win_loaded && it.lba >= win_base && it.lba - win_base < WIN_BLOCKS)
                        r.read_data = win_img[(it.lba - win_base) * BLOCK_BYTES
                                              + it.byte_offset];
                    else
                        r.read_data = medium_img[it.lba * BLOCK_BYTES + it.byte_offset];
                    r.transfer_done = it.transfer_last;
                end
            OP_WRITE:
                if (!med_ready)
                    r.status = STAT_NOT_READY;
                else if (!wr_enable)
                    r.status = STAT_PROTECT;
                else if (it.lba >= DISK_BLOCKS)
                    r.status = STAT_RANGE;
                else
                begin
                    if (load_win_img(it.lba, ob))
                    begin
                        r.flush_done = 1'b1;
                        r.flush_base = ob[FLUSH_BASE_W-1:0];
                    end
                    win_img[(it.lba - win_base) * BLOCK_BYTES + it.byte_offset] = it.write_data;
                    win_dirty = 1;
                    r.transfer_done = it.transfer_last;
                end
            OP_TEST_READY:
                r.status = med_ready ? STAT_OK : STAT_NOT_READY;
            OP_START_STOP:
                if (!it.start_flag)
                begin
                    ob = win_base;
                    if (flush_win_img())
                    begin
                        r.flush_done = 1'b1;
                        r.flush_base = ob[FLUSH_BASE_W-1:0];
                    end
                end
            OP_OTHER:
                if (it.command_code == CMD_SYNC_CACHE)
                begin
                    ob = win_base;
                    if (flush_win_img())
                    begin
                        r.flush_done = 1'b1;
                        r.flush_base = ob[FLUSH_BASE_W-1:0];
                    end
                end
                else if (it.command_code != CMD_PREVENT_ALLOW)
                    r.status = STAT_INVALID;
            default:
                r.status = STAT_INVALID;
        endcase
        return r;
    endfunction

    // Send one request, predicting its response at acceptance; valid stays
    // high after the accept so that a request with no gap follows at once
    task automatic send_request(fdw_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.opcode        <= it.opcode;
        req.lba           <= it.lba;
        req.byte_offset   <= it.byte_offset;
        req.write_data    <= it.write_data;
        req.start_flag    <= it.start_flag;
        req.command_code  <= it.command_code;
        req.transfer_last <= it.transfer_last;
        do
            @(posedge clk);
        while (!req.ready);
        pending_resp.push_back(predict_cache_resp(it));
        items_sent++;
    endtask

    // Response receiver with random stalls
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            check_response();
        end
    end

    task automatic check_response();
        fdw_resp_t e;
        resp_seen++;
        if (pending_resp.size() == 0)
        begin
            $error("response with no request outstanding");
            error_count++;
            return;
        end
        e = pending_resp.pop_front();
        if (rsp.flush_done)
            flush_seen++;
        if (rsp.status !== e.status)
        begin
            $error("status: expected %0d actual %0d", e.status, rsp.status);
            error_count++;
        end
        if (rsp.read_data !== e.read_data)
        begin
            $error("read_data: expected %0h actual %0h", e.read_data, rsp.read_data);
            error_count++;
        end
        if (rsp.flush_done !== e.flush_done)
        begin
            $error("flush_done: expected %0d actual %0d", e.flush_done, rsp.flush_done);
            error_count++;
        end
        if (rsp.flush_base !== e.flush_base)
        begin
            $error("flush_base: expected %0d actual %0d", e.flush_base, rsp.flush_base);
            error_count++;
        end
        if (rsp.transfer_done !== e.transfer_done)
        begin
            $error("transfer_done: expected %0d actual %0d", e.transfer_done,
                   rsp.transfer_done);
            error_count++;
        end
    endtask

    // Wait until every response is in, then let the block settle
    task automatic drain_responses();
        req.valid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (2 * (WIN_BYTES + 1) + 64) @(posedge clk);
    endtask

    // Config write, only while idle
    task automatic write_config(logic [CFG_IDX_W-1:0] idx, bit val);
        drain_responses();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_WRITE_ENABLE)
            wr_enable = val;
        else
            med_ready = val;
    endtask

    function automatic fdw_item_t make_item(logic [OPCODE_W-1:0] op, logic [LBA_W-1:0] lba,
                                            logic [OFF_W-1:0] off, logic [BYTE_W-1:0] wd);
        fdw_item_t it;
        it.opcode        = op;
        it.lba           = lba;
        it.byte_offset   = off;
        it.write_data    = wd;
        it.start_flag    = 1'($urandom_range(0, 1));
        it.command_code  = BYTE_W'($urandom_range(0, 255));
        it.transfer_last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic fdw_item_t random_item(int unsigned hot_base);
        fdw_item_t   it;
        int unsigned pick;
        logic [LBA_W-1:0] lba;
        pick = $urandom_range(0, 99);
        // mostly blocks near a few hot windows, sometimes anywhere or out of range
        if (pick < 70)
            lba = hot_base + $urandom_range(0, 2 * WIN_BLOCKS - 1);
        else if (pick < 85)
            lba = $urandom_range(0, DISK_BLOCKS - 1);
        else
            lba = $urandom();
        if (lba >= DISK_BLOCKS && pick < 85)
            lba = DISK_BLOCKS - 1;
        it = make_item(OP_READ, lba, OFF_W'($urandom_range(0, 511)),
                       BYTE_W'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.opcode = OP_WRITE;
        else if (pick < 85)
            it.opcode = OP_READ;
        else if (pick < 89)
            it.opcode = OP_TEST_READY;
        else if (pick < 93)
            it.opcode = OP_START_STOP;
        else if (pick < 98)
        begin
            it.opcode = OP_OTHER;
            case ($urandom_range(0, 2))
                0: it.command_code = CMD_SYNC_CACHE;
                1: it.command_code = CMD_PREVENT_ALLOW;
                default: ;
            endcase
        end
        else
            it.opcode = OPCODE_W'($urandom_range(5, 7));
        return it;
    endfunction

    // Directed: extremes, every opcode and command, window switches
    task automatic test_directed();
        send_request(make_item(OP_READ, 0, 0, 8'h00));
        send_request(make_item(OP_READ, DISK_BLOCKS - 1, 511, 8'h00));
        send_request(make_item(OP_READ, DISK_BLOCKS, 0, 8'h00));
        send_request(make_item(OP_READ, 32'hFFFF_FFFF, 511, 8'h00));
        send_request(make_item(OP_WRITE, 0, 0, 8'hA5));
        send_request(make_item(OP_WRITE, 7, 511, 8'h00));
        send_request(make_item(OP_READ, 0, 0, 8'h00));
        send_request(make_item(OP_WRITE, DISK_BLOCKS - 1, 511, 8'hFF));
        send_request(make_item(OP_READ, 7, 511, 8'h00));
        send_request(make_item(OP_WRITE, 32'hFFFF_FFFF, 0, 8'h5A));
        send_request(make_item(OP_TEST_READY, 0, 0, 8'h00));
        send_request(make_item(OP_OTHER, 0, 0, 8'h00));
        begin
            fdw_item_t it;
            it = make_item(OP_OTHER, 0, 0, 8'h00);
            it.command_code = CMD_SYNC_CACHE;
            send_request(it);
            send_request(it);
            it.command_code = CMD_PREVENT_ALLOW;
            send_request(it);
            it.command_code = 8'hFF;
            send_request(it);
            it = make_item(OP_WRITE, 16, 3, 8'h3C);
            send_request(it);
            it = make_item(OP_START_STOP, 0, 0, 8'h00);
            it.start_flag = 1'b1;
            send_request(it);
            it.start_flag = 1'b0;
            send_request(it);
            send_request(it);
            for (int op = 5; op <= 7; op++)
                send_request(make_item(OPCODE_W'(op), 0, 0, 8'h00));
        end
    endtask

    // Protect and not-ready settings, both registers at both values
    task automatic test_config_modes();
        write_config(CFG_WRITE_ENABLE, 1'b0);
        send_request(make_item(OP_WRITE, 8, 0, 8'h11));
        send_request(make_item(OP_WRITE, DISK_BLOCKS, 0, 8'h11));
        send_request(make_item(OP_READ, 16, 3, 8'h00));
        write_config(CFG_MEDIUM_READY, 1'b0);
        send_request(make_item(OP_READ, 0, 0, 8'h00));
        send_request(make_item(OP_WRITE, 0, 0, 8'h22));
        send_request(make_item(OP_TEST_READY, 0, 0, 8'h00));
        send_request(make_item(OP_START_STOP, 0, 0, 8'h00));
        write_config(CFG_WRITE_ENABLE, 1'b1);
        send_request(make_item(OP_WRITE, DISK_BLOCKS, 0, 8'h22));
        write_config(CFG_MEDIUM_READY, 1'b1);
    endtask

    // Random traffic in phases with different register settings
    task automatic test_random_traffic(int count);
        int unsigned hot;
        hot = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                hot = ($urandom_range(0, DISK_BLOCKS / WIN_BLOCKS - 1)) * WIN_BLOCKS;
            send_request(random_item(hot));
            if (n == count / 2)
                drain_responses();
        end
    endtask

    initial
    begin
        error_count = 0;
        items_sent  = 0;
        resp_seen   = 0;
        flush_seen  = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.lba = '0;
        req.byte_offset = '0;
        req.write_data = '0;
        req.start_flag = 1'b0;
        req.command_code = '0;
        req.transfer_last = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = 1'b0;
        for (int i = 0; i < MEDIUM_BYTES; i++)
            medium_img[i] = ERASED_BYTE;
        for (int i = 0; i < WIN_BYTES; i++)
            win_img[i] = '0;
        win_base = 0;
        win_loaded = 0;
        win_dirty = 0;
        wr_enable = 1;
        med_ready = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_modes();
        test_random_traffic(500);
        write_config(CFG_WRITE_ENABLE, 1'b0);
        test_random_traffic(150);
        write_config(CFG_MEDIUM_READY, 1'b0);
        test_random_traffic(80);
        write_config(CFG_MEDIUM_READY, 1'b1);
        write_config(CFG_WRITE_ENABLE, 1'b1);
        test_random_traffic(330);

        drain_responses();
        $display("Sent %0d requests, checked %0d responses, %0d window write-backs,",
                 items_sent, resp_seen, flush_seen);
        $display("across write-protect and not-ready register settings.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
